// ----- sv/sfm_pkg.sv -----
// Shared types and constants of the substring filter matcher.
package sfm_pkg;

  localparam int PATTERN_MAX_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int PAT_BYTES       = 8;

  localparam logic [15:0] MATCH_LIMIT_RST = 16'd1000;

  localparam logic [1:0] CFG_IDX_PATTERN_BYTES  = 2'd0;
  localparam logic [1:0] CFG_IDX_PATTERN_LENGTH = 2'd1;
  localparam logic [1:0] CFG_IDX_MATCH_LIMIT    = 2'd2;

  typedef struct packed {
    logic [7:0] character;
    logic       empty_string;
    logic       string_end;
  } sfm_in_t;

  typedef struct packed {
    logic [15:0] string_index;
    logic        matched;
    logic        limit_reached;
  } sfm_out_t;

  // One finished string, as handed from the front to the back.
  typedef struct packed {
    logic found;
  } sfm_evt_t;

endpackage

// ----- sv/substring_filter_matcher.sv -----
// Top level of the substring filter matcher: configuration registers and wiring.
//
// Usage:
//   Strings stream in on the in_ channel, one character per beat; string_end
//   marks the last character, and a beat with empty_string set stands for a
//   whole empty string (its other fields are ignored). Each finished string
//   yields one beat on the out_ channel with its wrapping 16-bit index, whether
//   it is a pattern hit under the match limit, and whether the limit is reached.
//   Registers are written on the cfg_ channel (index 0 pattern bytes, 1 pattern
//   length, 2 match limit); the user must write only while idle, unenforced by the
//   block. cfg_ready is always high and a write applies from the next character.
// Timing:
//   One input beat per cycle while the event queue has room. A string-ending beat
//   passes through the event queue and then the output register that holds the
//   limit check before its result shows on out_valid.
// Reset:
//   Pattern empty, length zero, limit 1000, all counters and the queue cleared.
// Stall:
//   When out_ready is low the output register holds; up to QUEUE_DEPTH further
//   results gather in the queue, then in_ready drops until the receiver drains.
module substring_filter_matcher import sfm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  sfm_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output sfm_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [8*PAT_BYTES-1:0] pattern_bytes_r;
  logic [3:0]             pattern_length_r;
  logic [15:0]            match_limit_r;

  logic     evt_valid, evt_ready;
  sfm_evt_t evt_push, evt_pop;
  logic     pop_valid, pop_ready;

  assign cfg_ready = 1'b1;

  // Write a register per beat; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r  <= '0;
      pattern_length_r <= '0;
      match_limit_r    <= MATCH_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_PATTERN_BYTES:  pattern_bytes_r  <= cfg_data[8*PAT_BYTES-1:0];
        CFG_IDX_PATTERN_LENGTH: pattern_length_r <= cfg_data[3:0];
        CFG_IDX_MATCH_LIMIT:    match_limit_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Front: shift characters into the window, match the pattern, flag string ends.
  sfm_front #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .pattern_bytes (pattern_bytes_r),
    .pattern_length(pattern_length_r),
    .evt_valid     (evt_valid),
    .evt_ready     (evt_ready),
    .evt           (evt_push)
  );

  // Queue: decouple the character stream from the result receiver.
  sfm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(evt_valid),
    .push_ready(evt_ready),
    .push_data (evt_push),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (evt_pop)
  );

  // Back: count strings and matches, apply the limit, hold the result beat.
  sfm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .evt        (evt_pop),
    .match_limit(match_limit_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ----- sv/sfm_front.sv -----
// Front part: character window, pattern compare and end-of-string events.
module sfm_front import sfm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  sfm_in_t                in_data,
  input  logic [8*PAT_BYTES-1:0] pattern_bytes,
  input  logic [3:0]             pattern_length,
  output logic                   evt_valid,
  input  logic                   evt_ready,
  output sfm_evt_t               evt
);

  localparam int CW      = $clog2(PATTERN_MAX + 1);
  localparam int EFF_MAX = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

  logic [7:0]    win_r [PATTERN_MAX];
  logic [7:0]    win_sh [PATTERN_MAX];
  logic [CW-1:0] seen_r, seen_nxt, seen_sh;
  logic          found_r, found_nxt;
  logic [3:0]    len;
  logic          cmp_ok;
  logic          hit;
  logic          found_now;
  logic [3:0]    pidx;
  logic          accept;

  assign in_ready = evt_ready;
  assign accept   = in_valid & in_ready;

  // Clamp the configured length to what the window can hold.
  assign len = (int'(pattern_length) > EFF_MAX) ? 4'(EFF_MAX) : pattern_length;

  always_comb begin
    win_sh[0] = in_data.character;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      win_sh[k] = win_r[k-1];
    end
    seen_sh = (seen_r == CW'(PATTERN_MAX)) ? seen_r : seen_r + CW'(1);
  end

  // Newest character sits at position 0; it lines up with the last pattern byte.
  always_comb begin
    cmp_ok = 1'b1;
    pidx   = 4'd0;
    for (int k = 0; k < EFF_MAX; k++) begin
      pidx = len - 4'(k + 1);
      if ((4'(k) < len) && (win_sh[k] != pattern_bytes[8*pidx[2:0] +: 8])) begin
        cmp_ok = 1'b0;
      end
    end
  end

  assign hit       = (len == 4'd0) || (cmp_ok && (int'(seen_sh) >= int'(len)));
  assign found_now = found_r | hit;

  assign evt_valid = accept & (in_data.empty_string | in_data.string_end);
  assign evt.found = in_data.empty_string ? 1'b0 : found_now;

  always_comb begin
    seen_nxt  = seen_r;
    found_nxt = found_r;
    if (accept && !in_data.empty_string) begin
      if (in_data.string_end) begin
        seen_nxt  = '0;
        found_nxt = 1'b0;
      end else begin
        seen_nxt  = seen_sh;
        found_nxt = found_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      found_r <= 1'b0;
    end else begin
      seen_r  <= seen_nxt;
      found_r <= found_nxt;
    end
  end

  // Window bytes beyond the seen count never decide a hit, so no reset.
  always_ff @(posedge clk) begin
    if (accept && !in_data.empty_string) begin
      win_r <= win_sh;
    end
  end

  a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(seen_r) <= PATTERN_MAX)
    else $error("character count beyond window depth");

endmodule

// ----- sv/sfm_queue.sv -----
// Short event queue between the front and the back.
module sfm_queue import sfm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  sfm_evt_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output sfm_evt_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  sfm_evt_t      mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= DEPTH)
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("push without pop did not grow the queue");

endmodule

// ----- sv/sfm_back.sv -----
// Back part: string and match counters, limit check and output register.
module sfm_back import sfm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  sfm_evt_t    evt,
  input  logic [15:0] match_limit,
  output logic        out_valid,
  input  logic        out_ready,
  output sfm_out_t    out_data
);

  logic        out_valid_r, out_valid_nxt;
  sfm_out_t    out_data_r;
  logic [15:0] sc_r, sc_nxt;
  logic [15:0] mc_r, mc_nxt, mc_new;
  logic        take;
  logic        hit;

  // Load a new result when the register is empty or being drained.
  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop_valid & pop_ready;

  assign hit    = evt.found && (mc_r < match_limit);
  assign mc_new = hit ? mc_r + 16'd1 : mc_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sc_nxt        = sc_r;
    mc_nxt        = mc_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      sc_nxt        = sc_r + 16'd1;
      mc_nxt        = mc_new;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sc_r        <= '0;
      mc_r        <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sc_r        <= sc_nxt;
      mc_r        <= mc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r.string_index  <= sc_r;
      out_data_r.matched       <= hit;
      out_data_r.limit_reached <= (mc_new >= match_limit);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (sc_r == $past(sc_r) + 16'd1))
    else $error("string index did not advance on a result");

  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.matched) |-> (mc_r != 16'd0))
    else $error("matched result with empty match count");

endmodule
